/* sv/bidt_pkg.sv */
// ============================================================================
// bidt_pkg: shared types and constants of the bucketed id table
// Holds the status and command codes, the table geometry and the entry
// layout used by the top level and the entry memory.
// ============================================================================
package bidt_pkg;

   // Number of buckets; the bucket is the top byte of the id.
   localparam int BUCKET_COUNT     = 256;
   localparam int BUCKET_SHIFT     = 24;
   localparam int BUCKET_W         = 8;
   localparam int SLOTS_PER_BUCKET = 8;

   localparam int ID_W    = 32;
   localparam int TYPE_W  = 8;
   localparam int VALUE_W = 32;

   // Command codes.
   localparam logic CMD_ADD    = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   // Result status codes.
   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_NOT_FOUND = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_ZERO_ID   = 2'd3
   } status_type;

   // One table entry as it sits in memory. An id of zero marks an empty slot.
   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [TYPE_W-1:0]  entry_type;
      logic [VALUE_W-1:0] entry_value;
   } entry_type;

   localparam int ENTRY_W = ID_W + TYPE_W + VALUE_W;

endpackage

/* sv/bidt_req_if.sv */
// ============================================================================
// bidt_req_if: request channel of the bucketed id table
// Valid/ready channel carrying one add or lookup command per transfer.
// ============================================================================
interface bidt_req_if
   import bidt_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic               command;
   logic [ID_W-1:0]    id;
   logic [TYPE_W-1:0]  entry_type;
   logic [VALUE_W-1:0] entry_value;

   modport source (output valid, output command, output id, output entry_type,
                   output entry_value, input ready);
   modport sink   (input valid, input command, input id, input entry_type,
                   input entry_value, output ready);
endinterface

/* sv/bidt_rsp_if.sv */
// ============================================================================
// bidt_rsp_if: response channel of the bucketed id table
// Valid/ready channel carrying one status with the found entry per transfer.
// ============================================================================
interface bidt_rsp_if
   import bidt_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic [TYPE_W-1:0]  found_type;
   logic [VALUE_W-1:0] found_value;

   modport source (output valid, output status, output found_type,
                   output found_value, input ready);
   modport sink   (input valid, input status, input found_type,
                   input found_value, output ready);
endinterface

/* sv/bidt_ram.sv */
// ============================================================================
// bidt_ram: entry memory of the bucketed id table
// Simple dual-port synchronous RAM, one write and one read port, with the
// read data registered.
// ============================================================================
module bidt_ram
   import bidt_pkg::*;
#(
   parameter int DEPTH  = BUCKET_COUNT * SLOTS_PER_BUCKET,
   parameter int ADDR_W = $clog2(BUCKET_COUNT * SLOTS_PER_BUCKET)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  entry_type         wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output entry_type         rd_data
);

   entry_type entry_mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/bucketed_id_table.sv */
// ============================================================================
// bucketed_id_table: bucketed identifier table with in-bucket linear probing
// Stores 32-bit ids with a type tag and a value in 256 buckets of
// SLOTS_PER_BUCKET slots; adds insert or update, lookups return the entry.
// ============================================================================
// Scan: after the request transfer the bucket is read one slot per cycle,
//    paced by the registered read of the single entry memory, and the result
//    is loaded into the output register once the scan finishes and that register is free.
// Requests: a new request is taken only when idle, the cycle after the
//    previous result is loaded.
// Reset: synchronous; afterwards a clearing pass zeroes every id, and no
//    request is taken until it finishes.
module bucketed_id_table
   import bidt_pkg::*;
#(
   parameter int SLOTS_PER_BUCKET = bidt_pkg::SLOTS_PER_BUCKET
) (
   input  logic       clock,
   input  logic       reset,
   bidt_req_if.sink   req_if,
   bidt_rsp_if.source rsp_if
);

   // Table geometry derived from the slot count.
   localparam int DEPTH  = BUCKET_COUNT * SLOTS_PER_BUCKET;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int SCAN_W = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;

   // Controller states, one-hot.
   typedef enum logic [2:0] {
      S_CLEAR = 3'b001,
      S_IDLE  = 3'b010,
      S_SCAN  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // Clearing pass address.
   logic [ADDR_W-1:0] clr_ff, clr_in;

   // Request held for the duration of a scan.
   logic               cmd_ff;
   logic [ID_W-1:0]    key_ff;
   logic [TYPE_W-1:0]  tag_ff;
   logic [VALUE_W-1:0] val_ff;
   logic               zero_ff;
   logic [ADDR_W-1:0]  base_ff;
   logic [SCAN_W-1:0]  scan_ff, scan_in;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff;
   logic [TYPE_W-1:0]  rsp_type_ff;
   logic [VALUE_W-1:0] rsp_value_ff;

   // Memory ports.
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   entry_type         wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   entry_type         rd_data;

   // Scan decisions.
   logic              req_xfer;
   logic              out_free;
   logic              slot_hit;
   logic              last_slot;
   logic              finish;
   logic              rsp_load;
   logic [ADDR_W-1:0] req_base;
   logic [ADDR_W-1:0] slot_addr;
   status_type        status_in;

   bidt_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // A request is taken only when idle. The output register parts the two
   // sides, so a result still waiting does not hold back the next request.
   assign req_if.ready = (state_ff == S_IDLE);
   assign req_xfer     = req_if.valid && req_if.ready;

   // The output register is free when empty or being drained this cycle.
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // The first slot of the requested bucket. The multiply is by a constant.
   assign req_base = ADDR_W'(req_if.id[ID_W-1 -: BUCKET_W] * SLOTS_PER_BUCKET);

   // The slot whose entry arrives from memory this cycle.
   assign slot_addr = base_ff + ADDR_W'(scan_ff);

   // An add stops at the first empty slot or at its own id; a lookup stops
   // only at its own id. A zero id would match an empty slot, so the status tests it first.
   always_comb begin
      if (cmd_ff == CMD_ADD) begin
         slot_hit = (rd_data.id == '0) || (rd_data.id == key_ff);
      end else begin
         slot_hit = (rd_data.id == key_ff);
      end
   end

   assign last_slot = (scan_ff == SCAN_W'(SLOTS_PER_BUCKET - 1));
   assign finish    = zero_ff || slot_hit || last_slot;
   assign rsp_load  = (state_ff == S_SCAN) && finish && out_free;

   always_comb begin
      if (zero_ff) begin
         status_in = STAT_ZERO_ID;
      end else if (slot_hit) begin
         status_in = STAT_OK;
      end else if (cmd_ff == CMD_ADD) begin
         status_in = STAT_FULL;
      end else begin
         status_in = STAT_NOT_FOUND;
      end
   end

   // Memory read and write control. While clearing, every entry is written
   // with zero. During a scan the next slot is read each cycle until the
   // scan finishes; an add with a free or matching slot writes it in the cycle its result loads.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = slot_addr;
      wr_data = '{id: key_ff, entry_type: tag_ff, entry_value: val_ff};
      rd_en   = 1'b0;
      rd_addr = req_base;
      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
         end
         S_IDLE: begin
            rd_en   = req_xfer;
            rd_addr = req_base;
         end
         S_SCAN: begin
            wr_en   = rsp_load && !zero_ff && slot_hit && (cmd_ff == CMD_ADD);
            rd_en   = !finish;
            rd_addr = slot_addr + ADDR_W'(1);
         end
         default: begin
            wr_en = 1'b0;
            rd_en = 1'b0;
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      scan_in  = scan_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            scan_in = '0;
            if (req_xfer) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end else if (!finish) begin
               scan_in = scan_ff + SCAN_W'(1);
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // Output valid: set on a load, cleared when the result transfers.
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request registers, captured at the request transfer.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         cmd_ff  <= req_if.command;
         key_ff  <= req_if.id;
         tag_ff  <= req_if.entry_type;
         val_ff  <= req_if.entry_value;
         zero_ff <= (req_if.id == '0);
         base_ff <= req_base;
      end
   end

   // Result payload. Only a lookup that hits returns the stored entry.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= status_in;
         if (!zero_ff && slot_hit && (cmd_ff == CMD_LOOKUP)) begin
            rsp_type_ff  <= rd_data.entry_type;
            rsp_value_ff <= rd_data.entry_value;
         end else begin
            rsp_type_ff  <= '0;
            rsp_value_ff <= '0;
         end
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = rsp_status_ff;
   assign rsp_if.found_type  = rsp_type_ff;
   assign rsp_if.found_value = rsp_value_ff;

   // A request transfer always starts a scan in the next cycle.
   a_xfer_starts_scan: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == S_SCAN))
      else $error("request transfer did not start a scan");

   // Only a nonzero add ever writes the table outside the clearing pass.
   a_write_only_add: assert property (@(posedge clock) disable iff (reset)
      (wr_en && (state_ff != S_CLEAR)) |-> ((cmd_ff == CMD_ADD) && !zero_ff))
      else $error("table written by a request that is not an add");

   // The scan never runs past the last slot of its bucket.
   a_scan_in_bucket: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (scan_ff <= SCAN_W'(SLOTS_PER_BUCKET - 1)))
      else $error("scan left its bucket");

   // A result is never loaded over one that has not yet transferred.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_if.ready))
      else $error("result overwritten before transfer");

endmodule
